@@ rtl/rpa_pkg.sv @@
// rpa_pkg: types and constants shared by the range page allocator
// used by rpa_cell, rpa_chain and range_page_allocator_top; depends on nothing
`default_nettype none

package rpa_pkg;

	localparam int IDX_W   = 6;
	localparam int CNT_W   = 6;
	localparam int WORD_W  = 64;
	localparam int ADDR_W  = 32;

	localparam logic [WORD_W-1:0] PAGE_BYTES = 64'h0000_0000_0000_1000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// scan packet handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_pkt_t;

	// entry write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] start;
		logic [WORD_W-1:0] extent;
	} wr_bus_t;

endpackage

`default_nettype wire

@@ rtl/rpa_cell.sv @@
// rpa_cell: one table entry (start, length) and one stage of the scan chain
// depends on rpa_pkg
`default_nettype none

module rpa_cell
	import rpa_pkg::*;
#(
	parameter int CELL_ID = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wr_bus_t          wr,
	input  wire logic [CNT_W-1:0] range_count,
	input  wire scan_pkt_t        pkt_in,
	output scan_pkt_t             pkt_out
);

	localparam bit ADDRESSABLE = (CELL_ID < (1 << IDX_W));

	logic [WORD_W-1:0] start_q;
	logic [WORD_W-1:0] extent_q;
	scan_pkt_t         pkt_q;

	logic wr_hit;
	logic active;
	logic usable;
	logic take;

	always_comb begin
		wr_hit = 1'b0;
		active = 1'b0;
		if (ADDRESSABLE) begin
			wr_hit = wr.en && (wr.index == IDX_W'(CELL_ID));
			active = IDX_W'(CELL_ID) < range_count;
		end
	end

	// length above one page, start inside [1 MiB, 4 GiB)
	assign usable = (extent_q > PAGE_BYTES) && (start_q[WORD_W-1:ADDR_W] == '0)
		&& (start_q[ADDR_W-1:20] != '0);
	assign take = pkt_in.valid && !pkt_in.found && active && usable;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			start_q  <= wr.start;
			extent_q <= wr.extent;
		end else if (take) begin
			start_q  <= start_q + PAGE_BYTES;
			extent_q <= extent_q - PAGE_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q.valid <= pkt_in.valid;
			pkt_q.found <= pkt_in.found || take;
			pkt_q.addr  <= take ? start_q[ADDR_W-1:0] : pkt_in.addr;
		end
	end

	assign pkt_out = pkt_q;

endmodule

`default_nettype wire

@@ rtl/rpa_chain.sv @@
// rpa_chain: row of table cells, the scan packet moves one cell per cycle
// depends on rpa_pkg and rpa_cell
`default_nettype none

module rpa_chain
	import rpa_pkg::*;
#(
	parameter int N = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wr_bus_t          wr,
	input  wire logic [CNT_W-1:0] range_count,
	input  wire scan_pkt_t        pkt_head,
	output scan_pkt_t             pkt_tail
);

	scan_pkt_t link [0:N];

	assign link[0] = pkt_head;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rpa_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr         (wr),
			.range_count(range_count),
			.pkt_in     (link[i]),
			.pkt_out    (link[i+1])
		);
	end

	assign pkt_tail = link[N];

endmodule

`default_nettype wire

@@ rtl/range_page_allocator_top.sv @@
// range_page_allocator_top: first-fit page allocator over a table of free ranges
// depends on rpa_pkg and rpa_chain (which holds the rpa_cell row)
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  tdata: entry_index, start_value, extent_value
//                                       tuser: op
//   m_*       out  m_tvalid / m_tready  tdata: page_address   tuser: no_page
//   cfg_*     in   cfg_valid/cfg_ready  cfg_data: range_count
//
// a write item completes at its transfer: the addressed cell loads at the transfer edge
// an allocate result is valid once the packet has passed every cell register, a pending
// register and the output register, whatever range_count says
// reset clears range_count and all control state; table contents stay undefined
// a result held in the output register blocks nothing; the next item is taken once the
// pending result has moved there
`default_nettype none

module range_page_allocator_top
	import rpa_pkg::*;
#(
	parameter int MAX_RANGES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [135:0]     s_tdata,   // [5:0] entry_index, [69:6] start_value,
	                                         // [133:70] extent_value, [135:134] zero
	input  wire logic             s_tuser,   // [0] op

	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [ADDR_W-1:0]     m_tdata,   // [31:0] page_address
	output logic                  m_tuser,   // [0] no_page

	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data   // [5:0] range_count
);

	logic [CNT_W-1:0]  range_count_q;
	logic              busy_q;      // allocate in flight, input closed
	logic              pend_q;      // scan finished, result not yet in output register
	logic [ADDR_W-1:0] pend_addr_q;
	logic              pend_fail_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_fail_q;

	logic      in_xfer;
	logic      out_free;
	wr_bus_t   wr;
	scan_pkt_t pkt_head;
	scan_pkt_t pkt_tail;

	assign s_tready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	// write broadcast to the cell row
	assign wr.en     = in_xfer && (s_tuser == OP_WRITE);
	assign wr.index  = s_tdata[5:0];
	assign wr.start  = s_tdata[69:6];
	assign wr.extent = s_tdata[133:70];

	// allocate request enters the first cell
	assign pkt_head.valid = in_xfer && (s_tuser == OP_ALLOC);
	assign pkt_head.found = 1'b0;
	assign pkt_head.addr  = '0;

	rpa_chain #(
		.N(MAX_RANGES)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.range_count(range_count_q),
		.pkt_head   (pkt_head),
		.pkt_tail   (pkt_tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q <= '0;
			busy_q        <= 1'b0;
			pend_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				range_count_q <= cfg_data;
			end

			if (pkt_head.valid) begin
				busy_q <= 1'b1;
			end else if (pend_q && out_free) begin
				busy_q <= 1'b0;
			end

			// tail packet and a pending result never coexist: one scan at a time
			if (pkt_tail.valid) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end

			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (pkt_tail.valid) begin
			pend_addr_q <= pkt_tail.found ? pkt_tail.addr : '0;
			pend_fail_q <= !pkt_tail.found;
		end
		if (pend_q && out_free) begin
			out_addr_q <= pend_addr_q;
			out_fail_q <= pend_fail_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_fail_q;

endmodule

`default_nettype wire

@@ tb/range_page_allocator_top_test.sv @@
`timescale 1ns / 1ps
// range_page_allocator_top_test: self-checking bench for the first-fit page allocator
// depends on rpa_pkg and range_page_allocator_top; keeps its own copy of the range table

module range_page_allocator_top_test;
	import rpa_pkg::*;

	localparam int ROW_LEN = 64;
	// an allocate walks the whole row plus two registers; margin on top of that
	localparam int SETTLE_CYCLES = ROW_LEN + 16;
	localparam logic [WORD_W-1:0] FLOOR_1M = 64'h0000_0000_0010_0000;
	localparam logic [WORD_W-1:0] LIMIT_4G = 64'h0000_0001_0000_0000;
	localparam logic [WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic              no_page;
	} page_grant_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [135:0]     s_tdata = '0;  // [5:0] entry_index, [69:6] start_value,
	                                 // [133:70] extent_value, [135:134] zero
	logic             s_tuser = 1'b0;  // [0] op
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ADDR_W-1:0] m_tdata;  // [31:0] page_address
	logic             m_tuser;   // [0] no_page
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;  // [5:0] range_count

	// shadow of the block's table and register
	logic [WORD_W-1:0] range_start [ROW_LEN];
	logic [WORD_W-1:0] range_extent [ROW_LEN];
	logic [CNT_W-1:0]  range_count_now = '0;

	page_grant_t grants_due[$];  // page grants still owed by the block, oldest first
	int          error_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;

	range_page_allocator_top #(.MAX_RANGES(ROW_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// first-fit scan: usable means longer than a page and start in [1 MiB, 4 GiB)
	function automatic page_grant_t grant_page();
		page_grant_t g;
		g.page_address = '0;
		g.no_page = 1'b1;
		for (int i = 0; i < int'(range_count_now) && i < ROW_LEN; i++) begin
			if (range_extent[i] > PAGE_BYTES && range_start[i] < LIMIT_4G &&
					range_start[i] >= FLOOR_1M) begin
				g.page_address = range_start[i][ADDR_W-1:0];
				g.no_page = 1'b0;
				range_start[i] = range_start[i] + PAGE_BYTES;
				range_extent[i] = range_extent[i] - PAGE_BYTES;
				return g;
			end
		end
		return g;
	endfunction

	// result checker: every output transfer is matched against the oldest grant
	always @(posedge clk) begin
		page_grant_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (grants_due.size() == 0) begin
				$error("result with no allocate pending: page_address %h no_page %b",
					m_tdata, m_tuser);
				error_count++;
			end else begin
				due = grants_due.pop_front();
				if (m_tdata !== due.page_address) begin
					$error("page_address expected %h actual %h", due.page_address, m_tdata);
					error_count++;
				end
				if (m_tuser !== due.no_page) begin
					$error("no_page expected %b actual %b", due.no_page, m_tuser);
					error_count++;
				end
			end
		end
	end

	// one input transfer; tvalid is left high so back-to-back items need no gap
	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] st, input logic [WORD_W-1:0] ext);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, ext, st, idx};
		do @(posedge clk); while (!s_tready);
		if (op == OP_WRITE) begin
			range_start[idx] = st;
			range_extent[idx] = ext;
		end else begin
			grants_due.push_back(grant_page());
		end
	endtask

	task automatic alloc_page();
		send_item(OP_ALLOC, IDX_W'($urandom_range(0, ROW_LEN - 1)), {$urandom, $urandom},
			{$urandom, $urandom});
	endtask

	// stop sending and wait until every owed grant has come back
	task automatic await_grants();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0) @(posedge clk);
	endtask

	// idle the block fully: also covers a write still in flight
	task automatic settle_block();
		await_grants();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_range_count(input logic [CNT_W-1:0] cnt);
		settle_block();
		cfg_data <= cnt;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		range_count_now = cnt;
	endtask

	// mostly well-formed ranges, some at the address limits, some pure noise
	task automatic pick_range(output logic [WORD_W-1:0] st, output logic [WORD_W-1:0] ext);
		logic [31:0] frame;
		frame = $urandom_range(32'h000F_FFFF, 32'h0000_0100);
		case ($urandom_range(0, 9))
			0, 1: begin
				st = {$urandom, $urandom};
				ext = {$urandom, $urandom};
			end
			2: begin
				case ($urandom_range(0, 5))
					0: st = FLOOR_1M - 1;
					1: st = FLOOR_1M;
					2: st = LIMIT_4G - PAGE_BYTES;
					3: st = LIMIT_4G - 1;
					4: st = LIMIT_4G;
					default: st = '0;
				endcase
				ext = PAGE_BYTES + $urandom_range(0, 1);
			end
			default: begin
				st = {32'h0, frame[19:0], 12'h000};
				if ($urandom_range(0, 3) == 0) st[11:0] = 12'($urandom);
				ext = {32'h0, $urandom_range(0, 8)} << 12;
				if ($urandom_range(0, 4) == 0) ext = ext + $urandom_range(1, 4095);
				if ($urandom_range(0, 19) == 0) ext = {$urandom, $urandom};
			end
		endcase
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		if (range_count_now != 0 && $urandom_range(0, 9) < 8)
			return IDX_W'($urandom_range(0, int'(range_count_now) - 1));
		return IDX_W'($urandom_range(0, ROW_LEN - 1));
	endfunction

	// out of reset the count is zero, so the scan touches nothing
	task automatic test_empty_scan();
		alloc_page();
		alloc_page();
	endtask

	// every entry written with a range that can never give a page
	task automatic test_unusable_table();
		for (int i = 0; i < ROW_LEN; i++) begin
			if (i % 2 == 0)
				send_item(OP_WRITE, IDX_W'(i), '0, ALL_ONES);
			else
				send_item(OP_WRITE, IDX_W'(i), ALL_ONES, '0);
		end
		set_range_count(CNT_W'(ROW_LEN - 1));
		alloc_page();
	endtask

	// floor, 4 GiB ceiling and one-page length, each on both sides
	task automatic test_page_limits();
		set_range_count(CNT_W'(8));
		send_item(OP_WRITE, 0, FLOOR_1M - 1, ALL_ONES);
		send_item(OP_WRITE, 1, LIMIT_4G, ALL_ONES);
		send_item(OP_WRITE, 2, 64'h0020_0000, PAGE_BYTES);
		send_item(OP_WRITE, 3, FLOOR_1M, PAGE_BYTES + 1);
		send_item(OP_WRITE, 4, LIMIT_4G - 1, 64'h2001);
		send_item(OP_WRITE, 5, LIMIT_4G - PAGE_BYTES, ALL_ONES);
		alloc_page();
		// an allocate carries fields that must be ignored
		send_item(OP_ALLOC, '1, ALL_ONES, ALL_ONES);
		send_item(OP_ALLOC, '0, '0, '0);
		alloc_page();
	endtask

	// the last entry the scan can reach, and one just beyond it
	task automatic test_scan_extremes();
		set_range_count(CNT_W'(ROW_LEN - 1));
		send_item(OP_WRITE, IDX_W'(ROW_LEN - 2), 64'h0040_0000, 64'h2000);
		send_item(OP_WRITE, IDX_W'(ROW_LEN - 1), 64'h0050_0000, ALL_ONES);
		alloc_page();
		alloc_page();
		set_range_count(CNT_W'(ROW_LEN - 1));
		alloc_page();
	endtask

	// hold the stream until the pipeline is empty, then go on
	task automatic test_drained_restart();
		set_range_count(CNT_W'(2));
		send_item(OP_WRITE, 0, 64'h0080_0000, 64'h3000);
		alloc_page();
		alloc_page();
		await_grants();
		alloc_page();
		send_item(OP_WRITE, 1, 64'h00C0_0000, 64'h1001);
		alloc_page();
	endtask

	task automatic run_traffic(input int tx_pct, input int rx_pct, input int n_items);
		logic [WORD_W-1:0] st;
		logic [WORD_W-1:0] ext;
		logic [CNT_W-1:0]  cnt;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: cnt = CNT_W'(ROW_LEN - 1);
				1: cnt = CNT_W'($urandom_range(1, 4));
				2: cnt = CNT_W'($urandom_range(5, ROW_LEN - 2));
				default: cnt = CNT_W'($urandom_range(0, ROW_LEN - 1));
			endcase
			set_range_count(cnt);
			for (int n = 0; n < n_items / 4; n++) begin
				if ($urandom_range(0, 99) == 0)
					await_grants();
				if ($urandom_range(0, 99) < 45) begin
					alloc_page();
				end else begin
					pick_range(st, ext);
					send_item(OP_WRITE, pick_index(), st, ext);
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_scan();
		test_unusable_table();
		test_page_limits();
		test_scan_extremes();
		test_drained_restart();
		// receiver slow first, then sender slow, then full rate
		run_traffic(26, 71, 532);
		run_traffic(71, 26, 532);
		run_traffic(0, 0, 532);
		settle_block();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#(20_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rpa_pkg.sv
rtl/rpa_cell.sv
rtl/rpa_chain.sv
rtl/range_page_allocator_top.sv
tb/range_page_allocator_top_test.sv
